### rtl/deqb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue buffer.
// No dependencies; used by the interfaces, controller and datapath.
package deqb_pkg;

	typedef logic [2:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FN_PUSH_FRONT = 3'd0;
	localparam func_t FN_PUSH_BACK  = 3'd1;
	localparam func_t FN_POP_FRONT  = 3'd2;
	localparam func_t FN_POP_BACK   = 3'd3;
	localparam func_t FN_PEEK_FRONT = 3'd4;
	localparam func_t FN_PEEK_BACK  = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		logic    exec;
		func_t   func;
		logic    load_imm;
		logic    load_mem;
		status_t status;
	} deqb_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} deqb_sts_t;

endpackage

### rtl/deqb_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the double-ended queue buffer.
// Depends on deqb_pkg for the function and status types.
interface deqb_req_if #(
	parameter int DATA_WIDTH = 8
);
	logic                  valid;
	logic                  ready;
	deqb_pkg::func_t       func;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface deqb_rsp_if #(
	parameter int DATA_WIDTH = 8,
	parameter int DEPTH      = 16
);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] data_out;
	logic [CW-1:0]         count_out;
	deqb_pkg::status_t     status;

	modport source (output valid, output data_out, output count_out, output status,
		input ready);
	modport sink   (input valid, input data_out, input count_out, input status,
		output ready);
endinterface

### rtl/deqb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deqb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/deqb_ctrl.sv
`timescale 1ns / 1ps
// Controller: request acceptance, status decision, response register load.
// Depends on deqb_pkg.
module deqb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  deqb_pkg::func_t     in_func,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  deqb_pkg::deqb_sts_t sts,
	output deqb_pkg::deqb_cmd_t cmd
);
	import deqb_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RD   = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;
	logic acc;
	logic is_push;
	logic is_read;
	logic err_full;
	logic err_empty;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		is_push = 1'b0;
		is_read = 1'b0;
		unique case (in_func) inside
			FN_PUSH_FRONT, FN_PUSH_BACK: is_push = 1'b1;
			FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: is_read = 1'b1;
			default: ;
		endcase
	end

	assign err_full  = is_push && sts.full;
	assign err_empty = is_read && sts.empty;

	always_comb begin
		cmd.exec     = acc && (is_push || is_read) && !err_full && !err_empty;
		cmd.func     = in_func;
		cmd.load_imm = acc && !(is_read && !sts.empty);
		cmd.load_mem = (state_q == S_RD) && slot_free;
		cmd.status   = err_full ? ST_FULL : (err_empty ? ST_EMPTY : ST_OK);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && is_read && !sts.empty) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_imm || cmd.load_mem) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/deqb_dp.sv
`timescale 1ns / 1ps
// Datapath: ring pointers, element count, slot RAM and response register.
// Depends on deqb_pkg and deqb_ram.
module deqb_dp #(
	parameter int DATA_WIDTH = 8,
	parameter int DEPTH      = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  deqb_pkg::deqb_cmd_t          cmd,
	input  logic [DATA_WIDTH-1:0]        in_value,
	output deqb_pkg::deqb_sts_t          sts,
	output logic [DATA_WIDTH-1:0]        data_out,
	output logic [$clog2(DEPTH+1)-1:0]   count_out,
	output deqb_pkg::status_t            status
);
	import deqb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0]         head_q, tail_q, head_d, tail_d;
	logic [AW-1:0]         head_next, head_prev, tail_next, tail_prev;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] rdata;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CW-1:0]         count_q;
	status_t               status_q;

	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST : tail_q - 1'b1;

	assign sts.empty = (cnt_q == '0);
	assign sts.full  = (cnt_q == CW'(DEPTH));

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		cnt_d  = cnt_q;
		we     = 1'b0;
		re     = 1'b0;
		waddr  = tail_q;
		raddr  = head_q;
		if (cmd.exec) begin
			unique case (cmd.func)
				FN_PUSH_FRONT: begin
					we     = 1'b1;
					waddr  = head_prev;
					head_d = head_prev;
					cnt_d  = cnt_q + 1'b1;
				end
				FN_PUSH_BACK: begin
					we     = 1'b1;
					waddr  = tail_q;
					tail_d = tail_next;
					cnt_d  = cnt_q + 1'b1;
				end
				FN_POP_FRONT: begin
					re     = 1'b1;
					raddr  = head_q;
					head_d = head_next;
					cnt_d  = cnt_q - 1'b1;
				end
				FN_POP_BACK: begin
					re     = 1'b1;
					raddr  = tail_prev;
					tail_d = tail_prev;
					cnt_d  = cnt_q - 1'b1;
				end
				FN_PEEK_FRONT: begin
					re    = 1'b1;
					raddr = head_q;
				end
				FN_PEEK_BACK: begin
					re    = 1'b1;
					raddr = tail_prev;
				end
				default: ;
			endcase
		end
	end

	deqb_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			data_q   <= '0;
			count_q  <= cnt_d;
			status_q <= cmd.status;
		end else if (cmd.load_mem) begin
			data_q   <= rdata;
			count_q  <= cnt_q;
			status_q <= ST_OK;
		end
	end

	assign data_out  = data_q;
	assign count_out = count_q;
	assign status    = status_q;
endmodule

### rtl/double_ended_queue_buffer_unit.sv
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue (ring buffer in a RAM).
// Depends on deqb_pkg, deqb_if, deqb_ctrl, deqb_dp, deqb_ram.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | func, value
//  rsp     | out | valid/ready  | data_out, count_out, status
//
// Pushes, failed requests and unused codes are accepted and answered into
// the response register at the same edge.
// A successful pop or peek answers from the registered RAM read, in S_RD.
// Reset clears pointers, count and control; slot contents are not cleared.
// A new request is taken while a response waits only if that response is
// being taken in the same cycle.
module double_ended_queue_buffer_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 8
) (
	input logic                        clk,
	input logic                        arst_n,
	deqb_req_if.sink                   req,
	deqb_rsp_if.source                 rsp
);
	import deqb_pkg::*;

	deqb_cmd_t cmd;
	deqb_sts_t sts;
	logic      in_ready;
	logic      out_valid;

	deqb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_func   (req.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	deqb_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.DEPTH      (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_value  (req.value),
		.sts       (sts),
		.data_out  (rsp.data_out),
		.count_out (rsp.count_out),
		.status    (rsp.status)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	a_no_double_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_imm && cmd.load_mem))
		else $error("immediate and memory response load in same cycle");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_imm || cmd.load_mem) |-> (!rsp.valid || rsp.ready))
		else $error("response register overwritten before transaction");

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !cmd.load_imm) |=> !req.ready)
		else $error("request accepted while RAM read pending");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.data_out == '0))
		else $error("nonzero data on failed request");
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_buffer_unit: directed and random
// requests, response prediction and checking. Depends on deqb_pkg, deqb_if.
module tb;
	import deqb_pkg::*;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 8;
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_REPORTS  = 10;

	localparam func_t FN_SPARE_6 = 3'd6;
	localparam func_t FN_SPARE_7 = 3'd7;

	typedef struct {
		func_t                 func;
		logic [DATA_WIDTH-1:0] value;
		int unsigned           gap;
		bit                    drain;
	} deq_request_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] data;
		logic [CW-1:0]         count;
		status_t               status;
	} deq_answer_t;

	logic clk;
	logic arst_n;

	deqb_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
	deqb_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) rsp_ch ();

	double_ended_queue_buffer_unit #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	deq_request_t request_q[$];
	deq_answer_t  pending_answers[$];

	logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
	int unsigned           front_ptr;
	int unsigned           back_ptr;
	int unsigned           fill_count;

	int unsigned mismatch_cnt;
	int unsigned answer_cnt;
	int unsigned full_hits;
	int unsigned empty_hits;
	int unsigned spare_hits;
	int unsigned cycle_cnt;

	logic        req_taken;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned calm_left;

	// ring buffer predictor; updates the shadow state for one accepted request
	function automatic deq_answer_t apply_request(func_t f, logic [DATA_WIDTH-1:0] v);
		deq_answer_t a;
		a.data   = '0;
		a.status = ST_OK;
		case (f)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (fill_count >= DEPTH) begin
					a.status = ST_FULL;
					full_hits++;
				end else if (f == FN_PUSH_FRONT) begin
					front_ptr = (front_ptr == 0) ? DEPTH - 1 : front_ptr - 1;
					slot_mem[front_ptr] = v;
					fill_count++;
				end else begin
					slot_mem[back_ptr] = v;
					back_ptr = (back_ptr == DEPTH - 1) ? 0 : back_ptr + 1;
					fill_count++;
				end
			end
			FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
				if (fill_count == 0) begin
					a.status = ST_EMPTY;
					empty_hits++;
				end else if (f == FN_POP_FRONT) begin
					a.data = slot_mem[front_ptr];
					front_ptr = (front_ptr == DEPTH - 1) ? 0 : front_ptr + 1;
					fill_count--;
				end else if (f == FN_POP_BACK) begin
					back_ptr = (back_ptr == 0) ? DEPTH - 1 : back_ptr - 1;
					a.data = slot_mem[back_ptr];
					fill_count--;
				end else if (f == FN_PEEK_FRONT) begin
					a.data = slot_mem[front_ptr];
				end else begin
					a.data = slot_mem[(back_ptr == 0) ? DEPTH - 1 : back_ptr - 1];
				end
			end
			default: spare_hits++;
		endcase
		a.count = CW'(fill_count);
		return a;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		else if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_request(func_t f, logic [DATA_WIDTH-1:0] v, int unsigned gap,
		bit drain);
		deq_request_t r;
		r.func  = f;
		r.value = v;
		r.gap   = gap;
		r.drain = drain;
		request_q.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = FN_PUSH_FRONT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	initial begin
		front_ptr    = 0;
		back_ptr     = 0;
		fill_count   = 0;
		mismatch_cnt = 0;
		answer_cnt   = 0;
		full_hits    = 0;
		empty_hits   = 0;
		spare_hits   = 0;
		cycle_cnt    = 0;
		req_taken    = 1'b0;
		gap_left     = 0;
		stall_left   = 0;
		calm_left    = 0;
		for (int i = 0; i < DEPTH; i++)
			slot_mem[i] = '0;
	end

	// driver: new transaction at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (request_q.size() > 0 &&
					(!request_q[0].drain || pending_answers.size() == 0)) begin
					req_ch.func  <= request_q[0].func;
					req_ch.value <= request_q[0].value;
					req_ch.valid <= 1'b1;
					void'(request_q.pop_front());
					if (request_q.size() > 0)
						gap_left = request_q[0].gap;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		int unsigned roll;
		if (arst_n) begin
			if (calm_left > 0) begin
				calm_left--;
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				roll = $urandom_range(0, 999);
				if (roll < 5)
					calm_left = $urandom_range(50, 200);
				else if (roll < 160)
					stall_left = $urandom_range(0, 2);
				else if (roll < 175)
					stall_left = $urandom_range(9, 29);
				rsp_ch.ready <= (roll < 5 || roll >= 175);
			end
		end
	end

	// monitor: check taken responses, then predict the request taken at this edge
	always @(posedge clk) begin
		deq_answer_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				answer_cnt++;
				if (pending_answers.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: unexpected response data=%0h count=%0d status=%0d",
							$realtime, rsp_ch.data_out, rsp_ch.count_out, rsp_ch.status);
				end else begin
					want = pending_answers.pop_front();
					if (rsp_ch.data_out !== want.data || rsp_ch.count_out !== want.count ||
						rsp_ch.status !== want.status) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTS)
							$display("%0t: exp d=%0h c=%0d s=%0d got d=%0h c=%0d s=%0d",
								$realtime, want.data, want.count, want.status,
								rsp_ch.data_out, rsp_ch.count_out, rsp_ch.status);
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				pending_answers.push_back(apply_request(req_ch.func, req_ch.value));
			req_taken <= req_ch.valid && req_ch.ready;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned seg_len;
		int unsigned bias;
		bit          quiet;
		func_t       f;
		int unsigned bias_tbl [5];

		bias_tbl = '{10, 30, 50, 70, 90};

		// empty cases
		queue_request(FN_POP_FRONT, 8'h5a, 0, 1'b0);
		queue_request(FN_POP_BACK, 8'h00, 0, 1'b0);
		queue_request(FN_PEEK_FRONT, 8'hff, pick_gap(), 1'b0);
		queue_request(FN_PEEK_BACK, 8'h00, 0, 1'b0);
		queue_request(FN_SPARE_6, 8'hff, 0, 1'b0);
		// fill to the limit from both ends, with wrap of the front pointer
		for (int i = 0; i < DEPTH; i++)
			queue_request((i % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hff : DATA_WIDTH'($urandom),
				pick_gap(), 1'b0);
		queue_request(FN_PUSH_FRONT, 8'hff, 0, 1'b0);
		queue_request(FN_PUSH_BACK, 8'h00, 0, 1'b0);
		queue_request(FN_SPARE_7, 8'h81, 0, 1'b0);
		queue_request(FN_PEEK_FRONT, 8'h00, 0, 1'b0);
		queue_request(FN_PEEK_BACK, 8'h00, 0, 1'b0);
		queue_request(FN_POP_FRONT, 8'h00, 0, 1'b0);
		queue_request(FN_POP_BACK, 8'h00, 0, 1'b0);

		// random segments with a drifting push bias, to swing between empty and full
		n = 0;
		while (n < RANDOM_ITEMS) begin
			seg_len = $urandom_range(20, 80);
			bias    = bias_tbl[$urandom_range(0, 4)];
			quiet   = ($urandom_range(0, 5) == 0);
			for (int k = 0; k < seg_len; k++) begin
				if ($urandom_range(0, 99) < 4)
					f = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
				else if ($urandom_range(0, 99) < bias)
					f = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
				else
					f = func_t'($urandom_range(FN_POP_FRONT, FN_PEEK_BACK));
				queue_request(f, DATA_WIDTH'($urandom), quiet ? 0 : pick_gap(),
					(n % 280 == 0));
				n++;
			end
		end

		@(posedge arst_n);
		while (request_q.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d responses: %0d full pushes, %0d empty reads, %0d spare codes",
			answer_cnt, full_hits, empty_hits, spare_hits);
		$display("mismatching responses: %0d", mismatch_cnt);
		if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
